### hdl/stochastic_binary_synapse_learning_defines.svh
// Assertion macros for the stochastic binary synapse learning block.
// Included by the top level; no other dependencies.
`ifndef STOCHASTIC_BINARY_SYNAPSE_LEARNING_DEFINES_SVH
`define STOCHASTIC_BINARY_SYNAPSE_LEARNING_DEFINES_SVH
`ifndef SYNTHESIS
`define SBSL_ASSERT(lbl, clk_s, rstn_s, prop_e, msg_s) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop_e)) else $error(msg_s);
`define SBSL_ASSERT_IMPL(lbl, clk_s, rstn_s, ante_e, cons_e, msg_s) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante_e) |-> (cons_e)) \
    else $error(msg_s);
`else
`define SBSL_ASSERT(lbl, clk_s, rstn_s, prop_e, msg_s)
`define SBSL_ASSERT_IMPL(lbl, clk_s, rstn_s, ante_e, cons_e, msg_s)
`endif
`endif

### hdl/sbsl_pkg.sv
// Package for the stochastic binary synapse learning block: field widths,
// operation and register codes, sequencer state type. No dependencies.
package sbsl_pkg;

  localparam int OP_W      = 2;
  localparam int ROW_W     = 64;
  localparam int ROW_IDX_W = 6;
  localparam int PROB_W    = 16;
  localparam int RNG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [OP_W-1:0] OP_LEARN = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PROB_DEP_01 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_DEP_10 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED    = 2'd2;

  localparam logic [RNG_W-1:0] RNG_RESET = 32'd1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RDOUT = 8'b0000_0010,
    S_RDJ   = 8'b0000_0100,
    S_LDJ   = 8'b0000_1000,
    S_LOOP  = 8'b0001_0000,
    S_FLUSH = 8'b0010_0000,
    S_WRJ   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

endpackage

### hdl/stochastic_binary_synapse_learning.sv
// Stochastic binary synapse learning block: one module around a row-wide weight memory.
// Depends on sbsl_pkg and stochastic_binary_synapse_learning_defines.svh.
//
// Items are taken one at a time; in_stall is low only while the sequencer is idle, and the
// result register lets the next item enter while a result waits. A read passes S_RDOUT and
// S_OUT on its way to the result, a row write or an unused op S_OUT only. A learn walks every
// pair k<j, one pair a cycle through the single weight memory (one read and one write port):
// row j is read and held, each pair decision that changes a weight does a read-modify-write
// of row k in the next cycle, and row j is written back at the end. Reset clears the matrix
// at once through per-row valid bits; no clearing pass is needed. Configuration writes take
// effect at the next edge.
`include "stochastic_binary_synapse_learning_defines.svh"

module stochastic_binary_synapse_learning #(
  parameter int NEURON_COUNT = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sbsl_pkg::OP_W-1:0]      in_op,
  input  logic [sbsl_pkg::ROW_W-1:0]     in_pattern_bits,
  input  logic [sbsl_pkg::ROW_IDX_W-1:0] in_row_index,
  input  logic [sbsl_pkg::ROW_W-1:0]     in_row_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sbsl_pkg::OP_W-1:0]      out_done_kind,
  output logic [sbsl_pkg::ROW_W-1:0]     out_weight_row,
  input  logic                           cfg_we,
  input  logic [sbsl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbsl_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import sbsl_pkg::*;

  localparam int N  = NEURON_COUNT;
  localparam int RW = $clog2(NEURON_COUNT);
  localparam logic [ROW_IDX_W:0] NC_EXT = (ROW_IDX_W+1)'(NEURON_COUNT);
  localparam logic [RW-1:0] J_LAST = RW'(NEURON_COUNT - 1);

  state_t state_r, state_nxt;

  logic [OP_W-1:0]   op_r;
  logic [N-1:0]      pat_r;
  logic [RW-1:0]     row_r;
  logic              row_ok_r;
  logic [RW-1:0]     j_r;
  logic [RW-1:0]     k_r;
  logic [N-1:0]      rowj_r;
  logic [ROW_W-1:0]  res_row_r;

  logic              pend_vld_r;
  logic [RW-1:0]     pend_k_r;
  logic              pend_bit_r;

  logic [N-1:0]      mem [N];
  logic [N-1:0]      vld_r;
  logic [N-1:0]      mem_rdata_r;
  logic              mem_rvld_r;
  logic              mem_re;
  logic [RW-1:0]     mem_raddr;
  logic              mem_we;
  logic [RW-1:0]     mem_waddr;
  logic [N-1:0]      mem_wdata;
  logic [N-1:0]      rd_row;

  logic [RNG_W-1:0]  rng_r;
  logic [PROB_W-1:0] p01_r;
  logic [PROB_W-1:0] p10_r;
  logic [RNG_W-1:0]  rng_x1, rng_x2, rng_x3;

  logic              out_vld_r;
  logic [OP_W-1:0]   out_kind_r;
  logic [ROW_W-1:0]  out_row_r;

  logic              in_xfer;
  logic              out_xfer;
  logic              out_free;
  logic              in_row_ok;
  logic              pj, pk, wt;
  logic              need_draw;
  logic              dep_hit;
  logic              set_hit;
  logic              change;
  logic              new_bit;
  logic [PROB_W-1:0] thr;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_vld_r && !out_stall;
  assign out_free  = !out_vld_r || !out_stall;
  assign in_row_ok = ({1'b0, in_row_index} < NC_EXT);

  assign out_valid      = out_vld_r;
  assign out_done_kind  = out_kind_r;
  assign out_weight_row = out_row_r;

  assign rd_row = mem_rvld_r ? mem_rdata_r : '0;

  // xorshift32 step
  assign rng_x1 = rng_r ^ (rng_r << 13);
  assign rng_x2 = rng_x1 ^ (rng_x1 >> 17);
  assign rng_x3 = rng_x2 ^ (rng_x2 << 5);

  assign pj        = pat_r[j_r];
  assign pk        = pat_r[k_r];
  assign wt        = rowj_r[k_r];
  assign need_draw = wt && (pj != pk);
  assign thr       = pk ? p01_r : p10_r;
  assign dep_hit   = need_draw && (rng_x3[PROB_W-1:0] < thr);
  assign set_hit   = !wt && pj && pk;
  assign change    = dep_hit || set_hit;
  assign new_bit   = set_hit;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = k_r;
    mem_we    = 1'b0;
    mem_waddr = j_r;
    mem_wdata = rowj_r;
    if (state_r == S_IDLE && in_xfer && in_op == OP_READ) begin
      mem_re    = 1'b1;
      mem_raddr = in_row_index[RW-1:0];
    end else if (state_r == S_RDJ) begin
      mem_re    = 1'b1;
      mem_raddr = j_r;
    end else if (state_r == S_LOOP) begin
      mem_re    = 1'b1;
      mem_raddr = k_r;
    end
    if (state_r == S_IDLE && in_xfer && in_op == OP_WRITE && in_row_ok) begin
      mem_we    = 1'b1;
      mem_waddr = in_row_index[RW-1:0];
      mem_wdata = in_row_data[N-1:0];
    end else if (pend_vld_r) begin
      mem_we           = 1'b1;
      mem_waddr        = pend_k_r;
      mem_wdata        = rd_row;
      mem_wdata[j_r]   = pend_bit_r;
    end else if (state_r == S_WRJ) begin
      mem_we    = 1'b1;
      mem_waddr = j_r;
      mem_wdata = rowj_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_op)
            OP_LEARN: state_nxt = S_RDJ;
            OP_READ:  state_nxt = S_RDOUT;
            default:  state_nxt = S_OUT;
          endcase
        end
      end
      S_RDOUT: state_nxt = S_OUT;
      S_RDJ:   state_nxt = S_LDJ;
      S_LDJ:   state_nxt = S_LOOP;
      S_LOOP:  state_nxt = (k_r == j_r - RW'(1)) ? S_FLUSH : S_LOOP;
      S_FLUSH: state_nxt = S_WRJ;
      S_WRJ:   state_nxt = (j_r == J_LAST) ? S_OUT : S_RDJ;
      S_OUT:   state_nxt = out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      vld_r      <= '0;
      mem_rvld_r <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      rng_r      <= RNG_RESET;
      p01_r      <= '0;
      p10_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        mem_rvld_r <= vld_r[mem_raddr];
      end
      pend_vld_r <= (state_r == S_LOOP) && change;
      if (state_r == S_LOOP && need_draw) begin
        rng_r <= rng_x3;
      end
      if (state_r == S_OUT && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_xfer) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROB_DEP_01: p01_r <= cfg_wdata[PROB_W-1:0];
          CFG_PROB_DEP_10: p10_r <= cfg_wdata[PROB_W-1:0];
          CFG_RNG_SEED:    rng_r <= (cfg_wdata == '0) ? RNG_RESET : cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r      <= in_op;
      pat_r     <= in_pattern_bits[N-1:0];
      row_r     <= in_row_index[RW-1:0];
      row_ok_r  <= in_row_ok;
      res_row_r <= '0;
      j_r       <= RW'(1);
    end
    case (state_r)
      S_RDOUT: begin
        res_row_r <= row_ok_r ? (ROW_W'(rd_row) | (ROW_W'(1) << row_r)) : '0;
      end
      S_LDJ: begin
        rowj_r <= rd_row;
        k_r    <= '0;
      end
      S_LOOP: begin
        if (change) begin
          rowj_r[k_r] <= new_bit;
        end
        pend_k_r   <= k_r;
        pend_bit_r <= new_bit;
        k_r        <= k_r + RW'(1);
      end
      S_WRJ: begin
        j_r <= j_r + RW'(1);
      end
      default: ;
    endcase
    if (state_r == S_OUT && out_free) begin
      out_kind_r <= op_r;
      out_row_r  <= res_row_r;
    end
  end

  `SBSL_ASSERT(a_rng_nonzero, clk, rst_n, rng_r != '0, "rng state reached zero")
  `SBSL_ASSERT_IMPL(a_loop_k_below_j, clk, rst_n, state_r == S_LOOP, k_r < j_r, "pair index k not below j")
  `SBSL_ASSERT_IMPL(a_pend_row_below_j, clk, rst_n, pend_vld_r, pend_k_r < j_r, "column write targets row j or above")
  `SBSL_ASSERT_IMPL(a_pend_in_learn, clk, rst_n, pend_vld_r, state_r == S_LOOP || state_r == S_FLUSH, "column write outside pair walk")

endmodule

### dv/testbench.sv
// Self-checking testbench for stochastic_binary_synapse_learning: directed table, then random
// learn/read/write traffic checked against an in-bench model of the weight matrix and dice.
// Depends on sbsl_pkg and the block RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sbsl_pkg::*;

  localparam int NEURONS = 64;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SEGMENTS = 6;
  localparam int SEG_ITEMS = 44;
  localparam int DIRECTED_ROWS = 19;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 2300;
  localparam int unsigned CYCLE_LIMIT = 2_500_000;

  typedef struct packed {
    logic [OP_W-1:0]  kind;
    logic [ROW_W-1:0] row;
  } done_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [ROW_W-1:0]     pat;
    logic [ROW_IDX_W-1:0] idx;
    logic [ROW_W-1:0]     data;
    logic                 typed;
    logic [ROW_W-1:0]     row_exp;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op;
  logic [ROW_W-1:0]     in_pattern_bits;
  logic [ROW_IDX_W-1:0] in_row_index;
  logic [ROW_W-1:0]     in_row_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OP_W-1:0]      out_done_kind;
  logic [ROW_W-1:0]     out_weight_row;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  stochastic_binary_synapse_learning #(.NEURON_COUNT(NEURONS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_pattern_bits(in_pattern_bits),
    .in_row_index   (in_row_index),
    .in_row_data    (in_row_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_done_kind  (out_done_kind),
    .out_weight_row (out_weight_row),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // model state
  logic [ROW_W-1:0]  weight_rows [NEURONS];
  logic [PROB_W-1:0] dep_prob_01;
  logic [PROB_W-1:0] dep_prob_10;
  logic [RNG_W-1:0]  seed_reg;
  logic [RNG_W-1:0]  dice_state;

  done_t       pending_done [$];
  done_t       oldest_done;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int          send_idle = 37;
  int          recv_idle = 61;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  logic [ROW_W-1:0] memory_pats [4];
  stim_row_t   directed [DIRECTED_ROWS];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [ROW_W-1:0] neuron_mask();
    if (NEURONS >= ROW_W) return '1;
    return (64'd1 << NEURONS) - 64'd1;
  endfunction

  function automatic logic [PROB_W-1:0] roll_dice();
    logic [RNG_W-1:0] x;
    x = dice_state;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    dice_state = x;
    return x[PROB_W-1:0];
  endfunction

  function automatic void learn_pattern(input logic [ROW_W-1:0] pat);
    logic fire_j;
    logic fire_k;
    logic [PROB_W-1:0] thr;
    for (int j = 1; j < NEURONS; j++) begin
      fire_j = pat[j];
      for (int k = 0; k < j; k++) begin
        fire_k = pat[k];
        if (weight_rows[j][k]) begin
          if (fire_j != fire_k) begin
            thr = fire_k ? dep_prob_01 : dep_prob_10;
            if (roll_dice() < thr) begin
              weight_rows[j][k] = 1'b0;
              weight_rows[k][j] = 1'b0;
            end
          end
        end else if (fire_j && fire_k) begin
          weight_rows[j][k] = 1'b1;
          weight_rows[k][j] = 1'b1;
        end
      end
    end
  endfunction

  function automatic done_t apply_synapse_item(input logic [OP_W-1:0] op,
                                               input logic [ROW_W-1:0] pat,
                                               input logic [ROW_IDX_W-1:0] idx,
                                               input logic [ROW_W-1:0] data);
    done_t r;
    r.kind = op;
    r.row = '0;
    case (op)
      OP_LEARN: learn_pattern(pat & neuron_mask());
      OP_READ: begin
        if (idx < NEURONS) r.row = (weight_rows[idx] & neuron_mask()) | (64'd1 << idx);
      end
      OP_WRITE: begin
        if (idx < NEURONS) weight_rows[idx] = data & neuron_mask();
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [ROW_W-1:0] want,
                                        input logic [ROW_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
  endfunction

  // result side: check each transfer, then pick the next stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_done.size() == 0) begin
          flag_mismatch("unexpected result, weight_row", '0, out_weight_row);
        end else begin
          oldest_done = pending_done.pop_front();
          if (out_done_kind !== oldest_done.kind)
            flag_mismatch("done_kind", ROW_W'(oldest_done.kind), ROW_W'(out_done_kind));
          if (out_weight_row !== oldest_done.row)
            flag_mismatch("weight_row", oldest_done.row, out_weight_row);
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] pat,
                           input logic [ROW_IDX_W-1:0] idx, input logic [ROW_W-1:0] data,
                           input logic typed, input logic [ROW_W-1:0] typed_row);
    done_t predicted;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_pattern_bits <= pat;
    in_row_index    <= idx;
    in_row_data     <= data;
    do @(posedge clk); while (in_stall);
    predicted = apply_synapse_item(op, pat, idx, data);
    if (typed) predicted.row = typed_row;
    pending_done.push_back(predicted);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_done.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_PROB_DEP_01: dep_prob_01 = val[PROB_W-1:0];
      CFG_PROB_DEP_10: dep_prob_10 = val[PROB_W-1:0];
      CFG_RNG_SEED: begin
        seed_reg   = val;
        dice_state = (seed_reg == '0) ? RNG_RESET : seed_reg;
      end
      default: ;
    endcase
  endtask

  task automatic configure(input logic [PROB_W-1:0] p01, input logic [PROB_W-1:0] p10,
                           input logic [RNG_W-1:0] seed);
    write_reg(CFG_PROB_DEP_01, {16'($urandom), p01});
    write_reg(CFG_PROB_DEP_10, {16'($urandom), p10});
    write_reg(CFG_RNG_SEED, seed);
    write_reg(CFG_UNUSED, $urandom);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ROW_W-1:0] random_pattern();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return a;
      1: return a & b & c;
      2: return a | b;
      default: return memory_pats[$urandom_range(3)] ^ (a & b & c & {$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] random_row_data();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random_item();
    int pick;
    logic [OP_W-1:0] op;
    pick = $urandom_range(99);
    if (pick < 35) op = OP_LEARN;
    else if (pick < 75) op = OP_READ;
    else if (pick < 95) op = OP_WRITE;
    else op = OP_UNUSED;
    send_item(op, random_pattern(), ROW_IDX_W'($urandom_range(NEURONS - 1)),
              random_row_data(), 1'b0, '0);
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_op           <= OP_LEARN;
    in_pattern_bits <= '0;
    in_row_index    <= '0;
    in_row_data     <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_PROB_DEP_01;
    cfg_wdata       <= '0;
    for (int i = 0; i < NEURONS; i++) weight_rows[i] = '0;
    dep_prob_01 = '0;
    dep_prob_10 = '0;
    seed_reg    = RNG_RESET;
    dice_state  = RNG_RESET;

    directed = '{
      '{OP_READ,   64'h0, 6'd0,  64'h0, 1'b1, 64'h1},
      '{OP_READ,   64'h0, 6'd63, 64'h0, 1'b1, 64'h8000_0000_0000_0000},
      '{OP_UNUSED, '1,    6'd63, '1,    1'b1, 64'h0},
      '{OP_LEARN,  64'h0, 6'd0,  64'h0, 1'b1, 64'h0},
      '{OP_LEARN,  '1,    6'd0,  64'h0, 1'b1, 64'h0},
      '{OP_READ,   64'h0, 6'd0,  64'h0, 1'b1, '1},
      '{OP_LEARN,  64'h5555_5555_5555_5555, 6'd0, 64'h0, 1'b1, 64'h0},
      '{OP_READ,   64'h0, 6'd31, 64'h0, 1'b0, 64'h0},
      '{OP_WRITE,  64'h0, 6'd10, 64'h0, 1'b1, 64'h0},
      '{OP_READ,   64'h0, 6'd10, 64'h0, 1'b1, 64'h400},
      '{OP_WRITE,  64'h0, 6'd63, '1,    1'b1, 64'h0},
      '{OP_WRITE,  64'h0, 6'd0,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'h0},
      '{OP_READ,   64'h0, 6'd0,  64'h0, 1'b0, 64'h0},
      '{OP_LEARN,  64'h8000_0000_0000_0001, 6'd0, 64'h0, 1'b0, 64'h0},
      '{OP_READ,   64'h0, 6'd63, 64'h0, 1'b0, 64'h0},
      '{OP_WRITE,  64'h0, 6'd20, 64'h0123_4567_89AB_CDEF, 1'b0, 64'h0},
      '{OP_LEARN,  64'hFFFF_0000_0000_FFFF, 6'd0, 64'h0, 1'b0, 64'h0},
      '{OP_READ,   64'h0, 6'd20, 64'h0, 1'b0, 64'h0},
      '{OP_UNUSED, 64'h0, 6'd0,  64'h0, 1'b1, 64'h0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_item(directed[i].op, directed[i].pat, directed[i].idx, directed[i].data,
                directed[i].typed, directed[i].row_exp);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      in_valid <= 1'b0;
      wait_drained();
      case (seg)
        0: configure(16'hFFFF, 16'hFFFF, 32'd0);
        1: configure(16'h8000, 16'h4000, 32'hFFFF_FFFF);
        2: configure(16'h0000, 16'hFFFF, $urandom);
        3: configure(16'hFFFF, 16'h0000, $urandom);
        4: configure(16'($urandom), 16'($urandom), $urandom);
        default: configure(16'($urandom_range(4095)), 16'($urandom_range(4095)), RNG_RESET);
      endcase
      if (seg < 2) begin
        send_idle = 37;
        recv_idle = 61;
      end else if (seg < 4) begin
        send_idle = 61;
        recv_idle = 37;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int m = 0; m < 4; m++) memory_pats[m] = {$urandom, $urandom};

      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (seg == 0 && i == 10) begin
          // long result hold-off while reads keep coming
          hold_req <= ~hold_req;
          repeat (6)
            send_item(OP_READ, '0, ROW_IDX_W'($urandom_range(NEURONS - 1)), '0, 1'b0, '0);
        end
        if (seg == 2 && i == 20) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_random_item();
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_done.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
